// ----- src/double_ended_queue_core_macros.svh -----
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define DEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks an implication on every rising clock edge while reset is released.
`define DEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/deq_pkg.sv -----
// Types, codes and constants of the double-ended queue.
package deq_pkg;

    localparam int DEQ_DEPTH = 16;
    localparam int DATA_W    = 32;

    // Operation codes carried in the kind field of a request.
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd1;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_DUMP       = 3'd4;

    // Status codes of a result.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic [1:0]               status;
        logic                     last;
    } rsp_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_F,
        OP_PUSH_B,
        OP_POP_F,
        OP_POP_B,
        OP_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] front_data;
    } cell_ctl_t;

endpackage

// ----- src/deq_cell.sv -----
// One storage cell of the deque chain, front side toward index zero.
module deq_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  deq_pkg::cell_ctl_t                ctl,
    input  logic signed [deq_pkg::DATA_W-1:0] prev_data,
    input  logic                              prev_valid,
    input  logic signed [deq_pkg::DATA_W-1:0] next_data,
    input  logic                              next_valid,
    output logic signed [deq_pkg::DATA_W-1:0] data,
    output logic                              valid
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     valid_reg;
    logic                     valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctl.op)
            OP_HOLD:
            begin
            end
            OP_PUSH_F:
            begin
                data_next  = prev_data;
                valid_next = prev_valid;
            end
            OP_PUSH_B:
            begin
                // The first empty cell behind an occupied one takes the value.
                if (!valid_reg && prev_valid)
                begin
                    data_next  = prev_data;
                    valid_next = 1'b1;
                end
            end
            OP_POP_F:
            begin
                data_next  = next_data;
                valid_next = next_valid;
            end
            OP_POP_B:
            begin
                if (valid_reg && !next_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            OP_ROT:
            begin
                // The tail cell wraps the front value around to the back.
                if (valid_reg)
                begin
                    data_next = next_valid ? next_data : ctl.front_data;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ----- src/double_ended_queue_core.sv -----
// Top level of the bounded double-ended queue built from a chain of cells.
`include "double_ended_queue_core_macros.svh"

// A bounded deque of signed 32-bit values held in a row of DEPTH cells, the
// front at cell zero. A push or a pop gives its one result in the output
// register, so these requests follow each other every cycle while the output
// side keeps up. A dump takes the request and then gives one result per stored
// entry, since the chain rotates by one cell per cycle while the output side
// keeps up and presents the front cell to the output register.
// No new request is taken during a dump. A push on a full queue gives status
// full, a pop or dump on an empty queue gives status empty, and requests with
// an unused kind are taken and give no result.
module double_ended_queue_core
#(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  deq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output deq_pkg::rsp_t rsp
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         remain_reg;
    logic [CNT_W-1:0]         remain_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]         cell_valid;
    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] tail_data;
    logic                     out_free;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     emit;
    rsp_t                     emit_rsp;

    assign full     = cell_valid[DEPTH-1];
    assign empty    = !cell_valid[0];
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_RUN) && out_free;
    assign accept   = req_valid && req_ready;

    // The tail is the only occupied cell that is the last cell or whose back neighbor is empty.
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_valid[i] && (i == DEPTH - 1 || !cell_valid[(i + 1) % DEPTH]))
            begin
                tail_data = tail_data | cell_data[i];
            end
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        remain_next        = remain_reg;
        ctl.op             = OP_HOLD;
        ctl.front_data     = cell_data[0];
        emit               = 1'b0;
        emit_rsp.value_res = '0;
        emit_rsp.status    = STATUS_OK;
        emit_rsp.last      = 1'b1;

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    case (req.kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                emit_rsp.status = STATUS_FULL;
                            end
                            else
                            begin
                                ctl.op     = (req.kind == KIND_PUSH_FRONT) ? OP_PUSH_F
                                                                           : OP_PUSH_B;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK:
                        begin
                            emit = 1'b1;
                            if (empty)
                            begin
                                emit_rsp.status = STATUS_EMPTY;
                            end
                            else if (req.kind == KIND_POP_FRONT)
                            begin
                                ctl.op             = OP_POP_F;
                                emit_rsp.value_res = cell_data[0];
                                count_next         = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                ctl.op             = OP_POP_B;
                                emit_rsp.value_res = tail_data;
                                count_next         = count_reg - CNT_W'(1);
                            end
                        end
                        KIND_DUMP:
                        begin
                            if (empty)
                            begin
                                emit            = 1'b1;
                                emit_rsp.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next  = ST_DUMP;
                                remain_next = count_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    ctl.op             = OP_ROT;
                    emit               = 1'b1;
                    emit_rsp.value_res = cell_data[0];
                    emit_rsp.last      = (remain_reg == CNT_W'(1));
                    remain_next        = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (out_free)
        begin
            rsp_valid_next = emit;
            rsp_next       = emit_rsp;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] prev_data;
            logic                     prev_valid;
            logic signed [DATA_W-1:0] next_data;
            logic                     next_valid;

            if (g == 0)
            begin : g_first
                // The new value enters at the front as if from a full neighbor.
                assign prev_data  = req.value;
                assign prev_valid = 1'b1;
            end
            else
            begin : g_inner
                assign prev_data  = (ctl.op == OP_PUSH_B && !cell_valid[g-1]) ? cell_data[g-1]
                                  : (ctl.op == OP_PUSH_B) ? req.value : cell_data[g-1];
                assign prev_valid = cell_valid[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign next_data  = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_body
                assign next_data  = cell_data[g+1];
                assign next_valid = cell_valid[g+1];
            end

            deq_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_data  (prev_data),
                .prev_valid (prev_valid),
                .next_data  (next_data),
                .next_valid (next_valid),
                .data       (cell_data[g]),
                .valid      (cell_valid[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            count_reg     <= '0;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Occupied cells always form one unbroken run starting at the front.
    `DEQ_ASSERT(a_cells_packed, ((cell_valid >> 1) & ~cell_valid) == '0, "deque cells not packed")
    // The entry count tracks the number of occupied cells.
    `DEQ_ASSERT(a_count_match, $countones(cell_valid) == int'(count_reg), "count mismatch")
    // Only a dump in progress produces results that are not the last of their request.
    `DEQ_ASSERT_IMPL(a_partial_dump, rsp_valid && !rsp.last, state_reg == ST_DUMP, "stray result")

endmodule
